// ===== sv/sgfi_pkg.sv =====
package sgfi_pkg;

  localparam int unsigned IDX_W   = 16;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned MAX_GAP = 63;
  // span N-M of a fillable gap runs 2 .. MAX_GAP+1
  localparam int unsigned SPAN_W  = $clog2(MAX_GAP + 2);
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);
  localparam int unsigned DIV_CNT_W = $clog2(VAL_W + 1);

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_FILL,
    CMD_WIDE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [VAL_W-1:0]   val;
    logic [IDX_W-1:0]   prev_idx;
    logic [VAL_W-1:0]   prev_val;
    logic [SPAN_W-1:0]  span;
  } cmd_t;

endpackage

// ===== sv/sgfi_front.sv =====
module sgfi_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sgfi_pkg::IDX_W-1:0]    in_sample_index,
  input  logic signed [sgfi_pkg::VAL_W-1:0] in_sample_value,
  output logic                          push,
  output sgfi_pkg::cmd_t                push_cmd,
  input  logic                          push_ready
);
  import sgfi_pkg::*;

  logic [IDX_W-1:0] prev_idx_r;
  logic [VAL_W-1:0] prev_val_r;
  logic             have_prev_r;
  logic [IDX_W:0]   span_full;
  logic             same_idx;
  logic             gap;
  logic             too_wide;
  logic             xfer;

  assign in_ready  = push_ready;
  assign xfer      = in_valid && in_ready;
  assign span_full = {1'b0, in_sample_index} - {1'b0, prev_idx_r};
  assign same_idx  = have_prev_r && (in_sample_index == prev_idx_r);
  // gap: index beyond last+1
  assign gap       = have_prev_r && (in_sample_index > prev_idx_r) &&
                     (span_full >= (IDX_W+1)'(2));
  assign too_wide  = span_full > (IDX_W+1)'(MAX_GAP + 1);

  assign push = xfer && !same_idx;

  always_comb begin
    push_cmd          = '0;
    push_cmd.idx      = in_sample_index;
    push_cmd.val      = in_sample_value;
    push_cmd.prev_idx = prev_idx_r;
    push_cmd.prev_val = prev_val_r;
    push_cmd.span     = span_full[SPAN_W-1:0];
    if (gap && too_wide) begin
      push_cmd.kind = CMD_WIDE;
    end else if (gap) begin
      push_cmd.kind = CMD_FILL;
    end else begin
      push_cmd.kind = CMD_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_idx_r  <= '0;
      prev_val_r  <= '0;
      have_prev_r <= 1'b0;
    end else if (push) begin
      prev_idx_r  <= in_sample_index;
      prev_val_r  <= in_sample_value;
      have_prev_r <= 1'b1;
    end
  end

endmodule

// ===== sv/sgfi_queue.sv =====
module sgfi_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  sgfi_pkg::cmd_t wr_data,
  output logic           wr_ready,
  output logic           rd_valid,
  output sgfi_pkg::cmd_t rd_data,
  input  logic           rd_en
);
  import sgfi_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = cnt_r != QCNT_W'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/sgfi_back.sv =====
module sgfi_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  sgfi_pkg::cmd_t                    cmd,
  output logic                              cmd_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sgfi_pkg::IDX_W-1:0]        out_index,
  output logic signed [sgfi_pkg::VAL_W-1:0] out_value,
  output logic                              out_is_interpolated,
  output logic                              out_gap_too_wide,
  output logic                              out_last_of_run
);
  import sgfi_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FILL,
    ST_ORIG
  } state_t;

  state_t               state_r;
  cmd_t                 cmd_r;
  logic [SPAN_W-1:0]    rem_r;
  logic [VAL_W-1:0]     dvd_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 neg_r;
  logic [VAL_W-1:0]     step_r;
  logic [VAL_W-1:0]     acc_r;
  logic [IDX_W-1:0]     fidx_r;
  logic [SPAN_W-1:0]    left_r;
  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_index_r;
  logic [VAL_W-1:0]     out_value_r;
  logic                 out_interp_r;
  logic                 out_wide_r;
  logic                 out_last_r;

  logic [VAL_W:0]       diff;
  logic [VAL_W:0]       diff_mag;
  logic [SPAN_W:0]      rem_sh;
  logic                 q_bit;
  logic [VAL_W-1:0]     step_fin;
  logic                 out_free;
  logic                 emit;

  assign diff     = {cmd.val[VAL_W-1], cmd.val} - {cmd.prev_val[VAL_W-1], cmd.prev_val};
  assign diff_mag = diff[VAL_W] ? -diff : diff;
  assign rem_sh   = {rem_r, dvd_r[VAL_W-1]};
  assign q_bit    = rem_sh >= {1'b0, cmd_r.span};
  // quotient ready in dvd_r after the last shift
  assign step_fin = neg_r ? -dvd_r : dvd_r;
  assign out_free = !out_valid_r || out_ready;
  // a new result is loaded this cycle
  assign emit     = out_free && ((state_r == ST_FILL) || (state_r == ST_ORIG));
  assign cmd_pop  = (state_r == ST_IDLE) && cmd_valid;

  assign out_valid           = out_valid_r;
  assign out_index           = out_index_r;
  assign out_value           = out_value_r;
  assign out_is_interpolated = out_interp_r;
  assign out_gap_too_wide    = out_wide_r;
  assign out_last_of_run     = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !emit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_r     <= cmd;
            rem_r     <= '0;
            dvd_r     <= diff_mag[VAL_W-1:0];
            neg_r     <= diff[VAL_W];
            div_cnt_r <= DIV_CNT_W'(VAL_W);
            if (cmd.kind == CMD_FILL) begin
              state_r <= ST_DIV;
            end else begin
              state_r <= ST_ORIG;
            end
          end
        end
        ST_DIV: begin
          if (div_cnt_r == '0) begin
            step_r  <= step_fin;
            acc_r   <= cmd_r.prev_val + step_fin;
            fidx_r  <= cmd_r.prev_idx + 1'b1;
            left_r  <= cmd_r.span - 1'b1;
            state_r <= ST_FILL;
          end else begin
            rem_r     <= q_bit ? SPAN_W'(rem_sh - {1'b0, cmd_r.span}) : rem_sh[SPAN_W-1:0];
            dvd_r     <= {dvd_r[VAL_W-2:0], q_bit};
            div_cnt_r <= div_cnt_r - 1'b1;
          end
        end
        ST_FILL: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_index_r  <= fidx_r;
            out_value_r  <= acc_r;
            out_interp_r <= 1'b1;
            out_wide_r   <= 1'b0;
            out_last_r   <= 1'b0;
            fidx_r       <= fidx_r + 1'b1;
            acc_r        <= acc_r + step_r;
            left_r       <= left_r - 1'b1;
            if (left_r == SPAN_W'(1)) begin
              state_r <= ST_ORIG;
            end
          end
        end
        ST_ORIG: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_index_r  <= cmd_r.idx;
            out_value_r  <= cmd_r.val;
            out_interp_r <= 1'b0;
            out_wide_r   <= cmd_r.kind == CMD_WIDE;
            out_last_r   <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/sample_gap_fill_interpolator.sv =====
// An item with nothing to fill passes through the queue, is taken by the back end and is
// then loaded into the output register. A fillable gap first runs the step division
// (16-step restoring divider), then gives one filled index per cycle while the receiver
// does not stall; a gap of N-M gives N-M results, the original sample last.
// The back end handles one item at a time; the two-entry queue absorbs bursts.
// Reset: synchronous, active low; clears the held pair, queue and output register.
module sample_gap_fill_interpolator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sgfi_pkg::IDX_W-1:0]        in_sample_index,
  input  logic signed [sgfi_pkg::VAL_W-1:0] in_sample_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sgfi_pkg::IDX_W-1:0]        out_index,
  output logic signed [sgfi_pkg::VAL_W-1:0] out_value,
  output logic                              out_is_interpolated,
  output logic                              out_gap_too_wide,
  output logic                              out_last_of_run
);
  import sgfi_pkg::*;

  // front -> queue
  logic q_push;
  cmd_t q_push_cmd;
  logic q_push_ready;
  // queue -> back
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // Front end: holds the last accepted pair, drops repeats, and tags each
  // transfer as pass-through, fill or too-wide before queueing it.
  sgfi_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_index (in_sample_index),
    .in_sample_value (in_sample_value),
    .push            (q_push),
    .push_cmd        (q_push_cmd),
    .push_ready      (q_push_ready)
  );

  // Short command queue so the front can take new transfers while the
  // back end is still dividing or emitting filled samples.
  sgfi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_data  (q_push_cmd),
    .wr_ready (q_push_ready),
    .rd_valid (q_valid),
    .rd_data  (q_cmd),
    .rd_en    (q_pop)
  );

  // Back end: for a fill, bit-serial step division and an accumulator walk over the gap;
  // then the original sample; results go through a registered output.
  sgfi_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (q_valid),
    .cmd                 (q_cmd),
    .cmd_pop             (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_index           (out_index),
    .out_value           (out_value),
    .out_is_interpolated (out_is_interpolated),
    .out_gap_too_wide    (out_gap_too_wide),
    .out_last_of_run     (out_last_of_run)
  );

endmodule

// ===== sv/sgfi_checker.sv =====
module sgfi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_index,
  input logic        out_is_interpolated,
  input logic        out_gap_too_wide,
  input logic        out_last_of_run
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index))
    else $error("stalled result changed");

  a_fill_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_interpolated |-> !out_gap_too_wide && !out_last_of_run)
    else $error("filled sample carries original-item flags");

  a_wide_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gap_too_wide |-> out_last_of_run)
    else $error("too-wide flag on a non-final result");

  a_fill_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_is_interpolated |=>
      !out_valid || (out_index == 16'($past(out_index) + 16'd1)))
    else $error("filled indices not contiguous");

endmodule

bind sample_gap_fill_interpolator sgfi_checker u_sgfi_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_index           (out_index),
  .out_is_interpolated (out_is_interpolated),
  .out_gap_too_wide    (out_gap_too_wide),
  .out_last_of_run     (out_last_of_run)
);

// ===== dv/sample_gap_fill_interpolator_tb.sv =====
module sample_gap_fill_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sgfi_pkg::*;

  // Generous bound: every item filling a full gap, with every result stalled, stays well under it
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 30;

  // One emitted sample as the block should present it
  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val;
    logic                    filled;
    logic                    too_wide;
    logic                    run_end;
  } emitted_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [IDX_W-1:0]        in_sample_index;
  logic signed [VAL_W-1:0] in_sample_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [IDX_W-1:0]        out_index;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_is_interpolated;
  logic                    out_gap_too_wide;
  logic                    out_last_of_run;

  // Predictor copy of the held pair
  logic [IDX_W-1:0]        held_idx = '0;
  logic signed [VAL_W-1:0] held_val = '0;
  bit                      held_ok  = 1'b0;

  // Samples still owed by the block, oldest first
  emitted_t                pending_samples[$];

  // Stimulus bookkeeping: last index and value offered
  int gen_idx;
  int gen_val;

  // Idling controls; rx_hold counts down a forced output stall
  bit tx_idle;
  bit rx_idle;
  int rx_hold = 0;

  int cyc;
  int n_err;
  int n_in;
  int n_dropped;
  int n_res;
  int n_fill;
  int n_wide;
  int n_stall;

  sample_gap_fill_interpolator u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sample_index     (in_sample_index),
    .in_sample_value     (in_sample_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_index           (out_index),
    .out_value           (out_value),
    .out_is_interpolated (out_is_interpolated),
    .out_gap_too_wide    (out_gap_too_wide),
    .out_last_of_run     (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    wait (cyc >= CYCLE_LIMIT);
    $display("watchdog: no finish after %0d cycles", CYCLE_LIMIT);
    $display("sample_gap_fill_interpolator test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    n_err++;
    $display("MISMATCH @%0t %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Work out every sample an accepted transfer should produce, then update the held pair.
  // Fill values use the integer step (B-A)/(N-M), truncated toward zero as SV division does.
  task automatic predict_fill(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] val);
    emitted_t e;
    int       span;
    int       step;
    int       k;
    logic     wide;
    wide = 1'b0;
    // repeated index: dropped, state kept
    if (held_ok && idx == held_idx) begin
      n_dropped++;
      return;
    end
    if (held_ok && int'(idx) > int'(held_idx) + 1) begin
      span = int'(idx) - int'(held_idx);
      if (span - 1 > int'(MAX_GAP)) begin
        wide = 1'b1;
      end else begin
        step = (int'(val) - int'(held_val)) / span;
        for (k = 1; k < span; k++) begin
          e.idx      = IDX_W'(int'(held_idx) + k);
          e.val      = VAL_W'(int'(held_val) + step * k);
          e.filled   = 1'b1;
          e.too_wide = 1'b0;
          e.run_end  = 1'b0;
          pending_samples.push_back(e);
        end
      end
    end
    // the sample itself always closes the run (first, lower, next, gap or too wide)
    e.idx      = idx;
    e.val      = val;
    e.filled   = 1'b0;
    e.too_wide = wide;
    e.run_end  = 1'b1;
    pending_samples.push_back(e);
    held_idx = idx;
    held_val = val;
    held_ok  = 1'b1;
  endtask

  // Input monitor and result checker; values read here are those before the edge
  always @(posedge clk) begin
    emitted_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        n_in++;
        predict_fill(in_sample_index, in_sample_value);
      end
      if (in_valid && !in_ready) begin
        n_stall++;
      end
      if (out_valid && out_ready) begin
        n_res++;
        if (pending_samples.size() == 0) begin
          report_mismatch("result with nothing owed, out_index", int'(out_index), 0);
        end else begin
          want = pending_samples.pop_front();
          if (out_index !== want.idx)
            report_mismatch("out_index", int'(out_index), int'(want.idx));
          if (out_value !== want.val)
            report_mismatch($sformatf("out_value at index %0d", want.idx),
                            int'(out_value), int'(want.val));
          if (out_is_interpolated !== want.filled)
            report_mismatch($sformatf("out_is_interpolated at index %0d", want.idx),
                            int'(out_is_interpolated), int'(want.filled));
          if (out_gap_too_wide !== want.too_wide)
            report_mismatch($sformatf("out_gap_too_wide at index %0d", want.idx),
                            int'(out_gap_too_wide), int'(want.too_wide));
          if (out_last_of_run !== want.run_end)
            report_mismatch($sformatf("out_last_of_run at index %0d", want.idx),
                            int'(out_last_of_run), int'(want.run_end));
          if (want.filled) n_fill++;
          if (want.too_wide) n_wide++;
        end
      end
    end
  end

  // Receiver: random ready, or a held-off stretch while rx_hold runs down
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one sample and return at the edge where its transfer happens.
  // Valid is only dropped on an idle gap, never lowered and raised in one step.
  task automatic send_sample(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] val);
    if (tx_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_index <= idx;
    in_sample_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gen_idx = idx;
    gen_val = val;
  endtask

  // Sender pauses until every owed sample has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  // Mostly ascending indices with short gaps; some repeats, wide gaps and jumps anywhere.
  // Running past the top index wraps round, which gives a lower index.
  task automatic pick_sample(output logic [IDX_W-1:0] idx, output logic signed [VAL_W-1:0] val);
    int r;
    int n;
    int v;
    r = $urandom_range(99);
    if (r < 5)       n = gen_idx;
    else if (r < 45) n = gen_idx + 1;
    else if (r < 72) n = gen_idx + int'($urandom_range(8, 2));
    else if (r < 84) n = gen_idx + int'($urandom_range(64, 9));
    else if (r < 92) n = gen_idx + int'($urandom_range(4000, 65));
    else             n = int'($urandom_range(65535));
    idx = n[IDX_W-1:0];
    if ($urandom_range(1)) begin
      val = VAL_W'($urandom);
    end else begin
      v = gen_val + int'($urandom_range(600)) - 300;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      val = v[VAL_W-1:0];
    end
  endtask

  // Extremes of index and value, every special case at least once
  task automatic test_directed();
    send_sample(16'd0,     16'sd1234);   // first sample, index 0 is not a repeat
    send_sample(16'd0,     16'sd999);    // repeat: dropped
    send_sample(16'd1,     16'sh8000);   // next index
    send_sample(16'd3,     16'sh7FFF);   // two-wide span, largest step
    send_sample(16'd67,    16'sh8000);   // widest fillable gap, negative step
    send_sample(16'd132,   16'sd5);      // one past the limit: flagged, no fill
    send_sample(16'd10,    -16'sd7);     // lower index: passes straight through
    send_sample(16'd12,    -16'sd12);    // negative odd difference truncates toward zero
    send_sample(16'd14,    -16'sd9);     // positive odd difference
    send_sample(16'd65471, 16'sd100);    // far jump up: too wide
    send_sample(16'd65535, -16'sd100);   // fill right up to the top index
    send_sample(16'd65535, 16'sd7);      // repeat at the top
    send_sample(16'd0,     16'sd0);      // wrap down to zero
    send_sample(16'd1,     16'sh5555);
    send_sample(16'd2,     16'shAAAA);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering gapped samples,
  // so the queue fills and in_ready drops
  task automatic test_backpressure();
    int k;
    tx_idle = 1'b0;
    rx_hold = 400;
    for (k = 0; k < 8; k++) begin
      send_sample(IDX_W'(gen_idx + int'($urandom_range(64, 40))), VAL_W'($urandom));
    end
    tx_idle = 1'b1;
    wait_drained();
  endtask

  // Random stream with a stretch of back-to-back traffic on both sides in the middle
  task automatic test_random();
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val;
    int                      kept;
    kept = 0;
    while (kept < 87) begin
      tx_idle = !(kept >= 30 && kept < 60);
      rx_idle = tx_idle;
      pick_sample(idx, val);
      if (idx != IDX_W'(gen_idx)) kept++;
      send_sample(idx, val);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_sample_index <= '0;
    in_sample_value <= '0;
    out_ready       <= 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_drained();
    test_backpressure();
    test_random();
    wait_drained();
    // let any stray result show up
    repeat (100) @(posedge clk);

    $display("covered %0d input transfers (%0d repeats dropped), %0d results checked",
             n_in, n_dropped, n_res);
    $display("  %0d interpolated, %0d flagged too wide, input stalled %0d cycles",
             n_fill, n_wide, n_stall);
    if (n_err == 0) begin
      $display("sample_gap_fill_interpolator test passed");
    end else begin
      $display("sample_gap_fill_interpolator test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sgfi_pkg.sv
sv/sgfi_front.sv
sv/sgfi_queue.sv
sv/sgfi_back.sv
sv/sample_gap_fill_interpolator.sv
sv/sgfi_checker.sv
dv/sample_gap_fill_interpolator_tb.sv
